[rtl/core/cbde_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cbde_pkg: shared types and constants for the clap envelope
// Envelope constants, request and register codes, control FSM states and the
// status struct of the serial multiplier.
// ----------------------------------------------------------------------------
package cbde_pkg;

  // envelope shape
  localparam int          BURSTS       = 3;
  localparam int          STAGE_W      = 3;
  localparam logic [2:0]  BURSTS_S     = 3'(BURSTS);
  localparam logic [2:0]  LAST_STAGE_S = 3'(BURSTS + 1);
  localparam int          LEVEL_W      = 31;
  localparam logic [30:0] FULL_LEVEL   = 31'h7fff_0000;
  localparam logic [30:0] SILENT_BELOW = 31'h0000_ffff;
  localparam logic [30:0] INC_RESET    = 31'd4869428;

  // serial multiplier: 16 multiplier bits, one per cycle
  localparam int MUL_BITS = 16;
  localparam int MUL_CNT_W = $clog2(MUL_BITS + 1);

  // request codes
  localparam logic REQ_SAMPLE  = 1'b0;
  localparam logic REQ_TRIGGER = 1'b1;

  // register index (paddr[2])
  localparam logic REG_DECAY = 1'b0;
  localparam logic REG_BURST = 1'b1;

  // control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SCALE,
    ST_FINISH
  } state_e;

  // multiplier status
  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage : cbde_pkg
`default_nettype wire

[rtl/core/cbde_smul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cbde_smul: bit-serial signed-by-unsigned multiplier
// Shift-add multiplier: one multiplier bit per cycle, LSB first, with the
// running sum shifted right into a low-half shift register.
// ----------------------------------------------------------------------------
module cbde_smul (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  wire signed [15:0]   mcand_i,
  input  wire        [15:0]   mplier_i,
  output cbde_pkg::mul_stat_t stat_o,
  output logic       [31:0]   prod_o
);

  logic signed [17:0] acc_q, acc_d;
  logic        [15:0] low_q, low_d;
  logic        [15:0] mpl_q, mpl_d;
  logic signed [17:0] mcand_q, mcand_d;
  logic [cbde_pkg::MUL_CNT_W-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic done_q, done_d;
  logic signed [17:0] sum;

  // one add per cycle; sum bit 0 drops into the low half
  always_comb begin
    sum     = acc_q + (mpl_q[0] ? mcand_q : 18'sd0);
    acc_d   = acc_q;
    low_d   = low_q;
    mpl_d   = mpl_q;
    mcand_d = mcand_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      acc_d   = '0;
      low_d   = '0;
      mpl_d   = mplier_i;
      mcand_d = 18'(mcand_i);
      cnt_d   = cbde_pkg::MUL_CNT_W'(cbde_pkg::MUL_BITS);
      busy_d  = 1'b1;
    end else if (busy_q) begin
      acc_d = sum >>> 1;
      low_d = {sum[0], low_q[15:1]};
      mpl_d = mpl_q >> 1;
      cnt_d = cnt_q - cbde_pkg::MUL_CNT_W'(1);
      if (cnt_q == cbde_pkg::MUL_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    low_q   <= low_d;
    mpl_q   <= mpl_d;
    mcand_q <= mcand_d;
  end

  assign prod_o      = {acc_q[15:0], low_q};
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule : cbde_smul
`default_nettype wire

[rtl/core/clap_burst_decay_envelope.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// clap_burst_decay_envelope: hand-clap burst/decay amplitude envelope
// Shapes signed 16-bit audio with a quadratic envelope of several short
// bursts followed by one long decay.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i/in_ready_o): req_type_i selects a trigger
//    word (restarts the envelope at full level, produces no output word) or
//    a sample word (produces exactly one output word).
//  - Output channel (out_valid_o/out_ready_i): sample_out_o is the shaped
//    sample, active_o is set while the envelope still runs after it.
//  - APB port: reg 0 at 0x0 is the decay increment, reg 1 at 0x4 the burst
//    increment, 31 bits each. Write only while the block is idle.
//  - Timing: a trigger is taken in the idle state with no further steps. A
//    running sample makes two passes of the bit-serial multiplier, gain
//    then sample times gain, then goes through the finish state into the
//    output register. A silent sample skips the multiplier and goes
//    straight from the idle state to the finish state.
//  - One sample is worked on at a time; the next word is accepted while the
//    previous result still sits in the output register.
//  - When the receiver stalls, the finished result waits in the sequencer
//    until the output register frees up; no input is taken meanwhile.
//  - Reset: envelope silent (level 0, stage 0), both increments 4869428,
//    output register empty.
// ----------------------------------------------------------------------------
module clap_burst_decay_envelope (
  input  wire               clk_i,
  input  wire               rst_ni,
  // APB configuration port
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire        [2:0]  paddr,
  input  wire        [31:0] pwdata,
  output logic       [31:0] prdata,
  output logic              pready,
  // input words
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire               req_type_i,
  input  wire signed [15:0] sample_in_i,
  // output words
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic signed [15:0] sample_out_o,
  output logic              active_o
);

  cbde_pkg::state_e state_q, state_d;

  logic [30:0] decay_inc_q, burst_inc_q;
  logic [30:0] level_q, level_d;
  logic [2:0]  stage_q, stage_d;
  logic signed [15:0] samp_q;
  logic signed [15:0] res_samp_q, res_samp_d;
  logic res_act_q, res_act_d;
  logic out_valid_q;
  logic signed [15:0] out_samp_q;
  logic out_act_q;

  logic        in_acc, cfg_wr, out_free, running;
  logic [30:0] inc, lvl_sub, lvl_nx;
  logic [2:0]  stg_inc, stg_nx;
  logic        adv;
  logic        mul_start;
  logic signed [15:0] mul_mcand;
  logic [15:0] mul_mplier;
  logic [31:0] mul_prod;
  cbde_pkg::mul_stat_t mul_stat;

  // APB: always ready, decode on paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  always_comb begin
    unique case (paddr[2])
      cbde_pkg::REG_DECAY: prdata = {1'b0, decay_inc_q};
      cbde_pkg::REG_BURST: prdata = {1'b0, burst_inc_q};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_inc_q <= cbde_pkg::INC_RESET;
      burst_inc_q <= cbde_pkg::INC_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        cbde_pkg::REG_DECAY: decay_inc_q <= pwdata[30:0];
        cbde_pkg::REG_BURST: burst_inc_q <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // envelope step: saturating subtract, stage advance and reload
  assign running  = (stage_q <= cbde_pkg::BURSTS_S) && (level_q >= cbde_pkg::SILENT_BELOW);
  assign inc      = (stage_q < cbde_pkg::BURSTS_S) ? burst_inc_q : decay_inc_q;
  assign lvl_sub  = (level_q >= inc) ? (level_q - inc) : '0;
  assign adv      = lvl_sub < inc;
  assign stg_inc  = stage_q + 3'd1;
  assign stg_nx   = adv ? stg_inc : stage_q;
  assign lvl_nx   = !adv ? lvl_sub :
                    (stg_inc <= cbde_pkg::BURSTS_S) ? cbde_pkg::FULL_LEVEL : '0;

  assign in_acc   = in_valid_i & in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cbde_pkg::ST_IDLE: begin
        if (in_valid_i && req_type_i == cbde_pkg::REQ_SAMPLE) begin
          state_d = running ? cbde_pkg::ST_SQUARE : cbde_pkg::ST_FINISH;
        end
      end
      cbde_pkg::ST_SQUARE: begin
        if (mul_stat.done) state_d = cbde_pkg::ST_SCALE;
      end
      cbde_pkg::ST_SCALE: begin
        if (mul_stat.done) state_d = cbde_pkg::ST_FINISH;
      end
      cbde_pkg::ST_FINISH: begin
        if (out_free) state_d = cbde_pkg::ST_IDLE;
      end
      default: state_d = cbde_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    mul_start  = 1'b0;
    mul_mcand  = '0;
    mul_mplier = '0;
    unique case (state_q)
      cbde_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        mul_start  = in_valid_i && req_type_i == cbde_pkg::REQ_SAMPLE && running;
        mul_mcand  = {1'b0, lvl_sub[30:16]};
        mul_mplier = {1'b0, lvl_sub[30:16]};
      end
      cbde_pkg::ST_SQUARE: begin
        // gain = (h*h) >> 15
        mul_start  = mul_stat.done;
        mul_mcand  = samp_q;
        mul_mplier = {1'b0, mul_prod[29:15]};
      end
      cbde_pkg::ST_SCALE,
      cbde_pkg::ST_FINISH: ;
      default: ;
    endcase
  end

  // envelope state and pending result
  always_comb begin
    level_d    = level_q;
    stage_d    = stage_q;
    res_samp_d = res_samp_q;
    res_act_d  = res_act_q;
    if (in_acc) begin
      if (req_type_i == cbde_pkg::REQ_TRIGGER) begin
        level_d = cbde_pkg::FULL_LEVEL;
        stage_d = '0;
      end else if (running) begin
        level_d   = lvl_nx;
        stage_d   = stg_nx;
        res_act_d = (stg_nx <= cbde_pkg::BURSTS_S) && (lvl_nx >= cbde_pkg::SILENT_BELOW);
      end else begin
        level_d    = '0;
        res_samp_d = '0;
        res_act_d  = 1'b0;
      end
    end else if (state_q == cbde_pkg::ST_SCALE && mul_stat.done) begin
      res_samp_d = mul_prod[31:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cbde_pkg::ST_IDLE;
      level_q     <= '0;
      stage_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      level_q <= level_d;
      stage_q <= stage_d;
      if (state_q == cbde_pkg::ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    res_samp_q <= res_samp_d;
    res_act_q  <= res_act_d;
    if (in_acc) samp_q <= sample_in_i;
    if (state_q == cbde_pkg::ST_FINISH && out_free) begin
      out_samp_q <= res_samp_q;
      out_act_q  <= res_act_q;
    end
  end

  cbde_smul u_smul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mul_mcand),
    .mplier_i (mul_mplier),
    .stat_o   (mul_stat),
    .prod_o   (mul_prod)
  );

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_samp_q;
  assign active_o     = out_act_q;

`ifndef SYNTH
  // stage can only step once past the decay stage
  a_stage_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_q <= cbde_pkg::LAST_STAGE_S)
    else $error("envelope stage beyond final decay");

  // multiplier idles whenever the sequencer takes input
  a_mul_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cbde_pkg::ST_IDLE |-> !mul_stat.busy && !mul_stat.done)
    else $error("multiplier active while idle");

  // a multiplier result only shows up in a multiply state
  a_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_stat.done |-> (state_q == cbde_pkg::ST_SQUARE || state_q == cbde_pkg::ST_SCALE))
    else $error("multiplier done outside multiply states");

  // finishing with a free slot always presents a word next cycle
  a_finish_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cbde_pkg::ST_FINISH && out_free |=> out_valid_o)
    else $error("finished word not presented");
`endif

endmodule : clap_burst_decay_envelope
`default_nettype wire
